>>> rtl/core/hrlp_pkg.sv
// hrlp_pkg: shared types, codes and character classes for the request line parser
// no dependencies; imported by hrlp_parse, http_request_line_parser and the testbench
`default_nettype none

package hrlp_pkg;

  localparam int COUNT_BITS_DEFAULT = 16;
  localparam int BYTE_W             = 8;
  localparam int LEN_W              = 16;
  localparam int STATUS_W           = 3;
  localparam int VER_W              = 7;
  localparam int TDATA_IN_W         = 8;
  localparam int TDATA_OUT_W        = 72;

  localparam logic [LEN_W-1:0] MAX_URI_RESET = 16'd8192;
  localparam logic [LEN_W-1:0] OUT_MAX       = 16'hFFFF;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_BUSY     = 3'd0;
  localparam logic [STATUS_W-1:0] ST_DONE     = 3'd1;
  localparam logic [STATUS_W-1:0] ST_BAD      = 3'd2;
  localparam logic [STATUS_W-1:0] ST_VERSION  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_URI_LONG = 3'd4;

  // characters that the grammar names
  localparam logic [BYTE_W-1:0] CH_CR    = 8'h0d;
  localparam logic [BYTE_W-1:0] CH_LF    = 8'h0a;
  localparam logic [BYTE_W-1:0] CH_SP    = 8'h20;
  localparam logic [BYTE_W-1:0] CH_DEL   = 8'h7f;
  localparam logic [BYTE_W-1:0] CH_H     = 8'h48;
  localparam logic [BYTE_W-1:0] CH_T     = 8'h54;
  localparam logic [BYTE_W-1:0] CH_P     = 8'h50;
  localparam logic [BYTE_W-1:0] CH_SLASH = 8'h2f;
  localparam logic [BYTE_W-1:0] CH_DOT   = 8'h2e;
  localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [BYTE_W-1:0] CH_NINE  = 8'h39;
  localparam logic [BYTE_W-1:0] CH_UA    = 8'h41;
  localparam logic [BYTE_W-1:0] CH_UZ    = 8'h5a;
  localparam logic [BYTE_W-1:0] CH_LA    = 8'h61;
  localparam logic [BYTE_W-1:0] CH_LZ    = 8'h7a;
  localparam logic [BYTE_W-1:0] CH_USCORE = 8'h5f;
  localparam logic [BYTE_W-1:0] CH_DASH  = 8'h2d;

  typedef enum logic [14:0] {
    PH_START     = 15'b000000000000001,
    PH_METHOD    = 15'b000000000000010,
    PH_SP_URI    = 15'b000000000000100,
    PH_URI       = 15'b000000000001000,
    PH_AFTER_URI = 15'b000000000010000,
    PH_H         = 15'b000000000100000,
    PH_HT        = 15'b000000001000000,
    PH_HTT       = 15'b000000010000000,
    PH_HTTP      = 15'b000000100000000,
    PH_MAJ_FIRST = 15'b000001000000000,
    PH_MAJ       = 15'b000010000000000,
    PH_MIN_FIRST = 15'b000100000000000,
    PH_MIN       = 15'b001000000000000,
    PH_SP_END    = 15'b010000000000000,
    PH_CR_SEEN   = 15'b100000000000000
  } phase_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [LEN_W-1:0]    line_length;
    logic [LEN_W-1:0]    method_length;
    logic [LEN_W-1:0]    uri_offset;
    logic [LEN_W-1:0]    uri_length;
    logic                version_minor;
  } result_t;

  function automatic logic is_digit(input logic [BYTE_W-1:0] b);
    return (b >= CH_ZERO) && (b <= CH_NINE);
  endfunction

  function automatic logic is_token(input logic [BYTE_W-1:0] b);
    return ((b >= CH_UA) && (b <= CH_UZ)) || ((b >= CH_LA) && (b <= CH_LZ)) ||
           is_digit(b) || (b == CH_USCORE) || (b == CH_DASH);
  endfunction

  function automatic logic is_uri(input logic [BYTE_W-1:0] b);
    return (b >= CH_SP) && (b != CH_DEL);
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/hrlp_parse.sv
// hrlp_parse: line state registers and the per-byte parse step
// depends on hrlp_pkg
`default_nettype none

module hrlp_parse #(
  parameter int COUNT_BITS = hrlp_pkg::COUNT_BITS_DEFAULT
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        fire,
  input  wire logic [hrlp_pkg::BYTE_W-1:0] data_byte,
  input  wire logic [hrlp_pkg::LEN_W-1:0]  max_uri_length,
  output hrlp_pkg::result_t                result,
  output logic                             line_start
);
  import hrlp_pkg::*;

  localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

  phase_t                phase, phase_next;
  logic [COUNT_BITS-1:0] byte_count, byte_count_next;
  logic [COUNT_BITS-1:0] method_len, method_len_next;
  logic [COUNT_BITS-1:0] uri_begin, uri_begin_next;
  logic [COUNT_BITS-1:0] uri_len, uri_len_next;
  logic [VER_W-1:0]      major_value, major_value_next;
  logic [VER_W-1:0]      minor_value, minor_value_next;
  logic [STATUS_W-1:0]   st;
  logic [STATUS_W-1:0]   fin_st;
  logic [3:0]            dig;
  logic [31:0]           uri_len_ext;

  function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
    return (v == CNT_MAX) ? v : v + 1'b1;
  endfunction

  function automatic logic [LEN_W-1:0] clip(input logic [COUNT_BITS-1:0] v);
    logic [31:0] e;
    e = 32'(v);
    return (e > 32'(OUT_MAX)) ? OUT_MAX : e[LEN_W-1:0];
  endfunction

  assign dig         = 4'(data_byte - CH_ZERO);
  assign uri_len_ext = 32'(uri_len);

  // version is checked before uri length
  always_comb begin
    if (!((major_value == 7'd1) && (minor_value <= 7'd1))) begin
      fin_st = ST_VERSION;
    end else if (uri_len_ext > 32'(max_uri_length)) begin
      fin_st = ST_URI_LONG;
    end else begin
      fin_st = ST_DONE;
    end
  end

  always_comb begin
    st               = ST_BUSY;
    phase_next       = phase;
    byte_count_next  = sat_inc(byte_count);
    method_len_next  = method_len;
    uri_begin_next   = uri_begin;
    uri_len_next     = uri_len;
    major_value_next = major_value;
    minor_value_next = minor_value;
    unique case (phase)
      PH_START: begin
        if ((data_byte == CH_CR) || (data_byte == CH_LF)) begin
          phase_next = PH_START;
        end else if (is_token(data_byte)) begin
          method_len_next = COUNT_BITS'(1);
          phase_next      = PH_METHOD;
        end else begin
          st = ST_BAD;
        end
      end
      PH_METHOD: begin
        if (data_byte == CH_SP) begin
          phase_next = PH_SP_URI;
        end else if (is_token(data_byte)) begin
          method_len_next = sat_inc(method_len);
        end else begin
          st = ST_BAD;
        end
      end
      PH_SP_URI: begin
        if (data_byte == CH_SP) begin
          phase_next = PH_SP_URI;
        end else if (is_uri(data_byte)) begin
          uri_begin_next = byte_count;
          uri_len_next   = COUNT_BITS'(1);
          phase_next     = PH_URI;
        end else begin
          st = ST_BAD;
        end
      end
      PH_URI: begin
        if (data_byte == CH_SP) begin
          phase_next = PH_AFTER_URI;
        end else if (is_uri(data_byte)) begin
          uri_len_next = sat_inc(uri_len);
        end else begin
          st = ST_BAD;
        end
      end
      PH_AFTER_URI: begin
        if (data_byte == CH_SP) begin
          phase_next = PH_AFTER_URI;
        end else if (data_byte == CH_H) begin
          phase_next = PH_H;
        end else begin
          st = ST_BAD;
        end
      end
      PH_H: begin
        if (data_byte == CH_T) phase_next = PH_HT;
        else st = ST_BAD;
      end
      PH_HT: begin
        if (data_byte == CH_T) phase_next = PH_HTT;
        else st = ST_BAD;
      end
      PH_HTT: begin
        if (data_byte == CH_P) phase_next = PH_HTTP;
        else st = ST_BAD;
      end
      PH_HTTP: begin
        if (data_byte == CH_SLASH) phase_next = PH_MAJ_FIRST;
        else st = ST_BAD;
      end
      PH_MAJ_FIRST: begin
        if (is_digit(data_byte)) begin
          major_value_next = VER_W'(dig);
          phase_next       = PH_MAJ;
        end else begin
          st = ST_BAD;
        end
      end
      PH_MAJ: begin
        if (data_byte == CH_DOT) begin
          phase_next = PH_MIN_FIRST;
        end else if (is_digit(data_byte) && (major_value <= 7'd9)) begin
          major_value_next = VER_W'(major_value * 7'd10) + VER_W'(dig);
        end else begin
          st = ST_BAD;
        end
      end
      PH_MIN_FIRST: begin
        if (is_digit(data_byte)) begin
          minor_value_next = VER_W'(dig);
          phase_next       = PH_MIN;
        end else begin
          st = ST_BAD;
        end
      end
      PH_MIN: begin
        if (is_digit(data_byte)) begin
          if (minor_value <= 7'd9) begin
            minor_value_next = VER_W'(minor_value * 7'd10) + VER_W'(dig);
          end else begin
            st = ST_BAD;
          end
        end else if (data_byte == CH_CR) begin
          phase_next = PH_CR_SEEN;
        end else if (data_byte == CH_LF) begin
          st = fin_st;
        end else if (data_byte == CH_SP) begin
          phase_next = PH_SP_END;
        end else begin
          st = ST_BAD;
        end
      end
      PH_SP_END: begin
        if (data_byte == CH_SP) begin
          phase_next = PH_SP_END;
        end else if (data_byte == CH_CR) begin
          phase_next = PH_CR_SEEN;
        end else if (data_byte == CH_LF) begin
          st = fin_st;
        end else begin
          st = ST_BAD;
        end
      end
      PH_CR_SEEN: begin
        if (data_byte == CH_LF) st = fin_st;
        else st = ST_BAD;
      end
      default: begin
        st = ST_BAD;
      end
    endcase
  end

  always_comb begin
    result        = '0;
    result.status = st;
    if (st == ST_DONE) begin
      result.line_length   = clip(byte_count_next);
      result.method_length = clip(method_len);
      result.uri_offset    = clip(uri_begin);
      result.uri_length    = clip(uri_len);
      result.version_minor = minor_value[0];
    end
  end

  assign line_start = (phase == PH_START);

  // any final status re-arms for the next line
  always_ff @(posedge clk) begin
    if (rst || (fire && (st != ST_BUSY))) begin
      phase       <= PH_START;
      byte_count  <= '0;
      method_len  <= '0;
      uri_begin   <= '0;
      uri_len     <= '0;
      major_value <= '0;
      minor_value <= '0;
    end else if (fire) begin
      phase       <= phase_next;
      byte_count  <= byte_count_next;
      method_len  <= method_len_next;
      uri_begin   <= uri_begin_next;
      uri_len     <= uri_len_next;
      major_value <= major_value_next;
      minor_value <= minor_value_next;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/http_request_line_parser.sv
// http_request_line_parser: top level with input register, result register and config
// depends on hrlp_pkg and hrlp_parse
//
// channel     | dir | fields (lowest bit first)
// s_axis      | in  | data_byte[7:0]
// m_axis      | out | status[2:0] line_length[18:3] method_length[34:19]
//             |     | uri_offset[50:35] uri_length[66:51] version_minor[67], zero pad
// cfg_wr      | in  | max_uri_length[15:0]
//
// one byte per cycle sustained while the result register is not stalled; each result is registered
// the parse step sits between the input byte register and the result register
// rst clears line state, both valid flags and sets max_uri_length to 8192
// a stalled result register holds the byte in the input register; s_axis_tready
// stays high while the input register is empty or passes its byte on
`default_nettype none

module http_request_line_parser #(
  parameter int COUNT_BITS = hrlp_pkg::COUNT_BITS_DEFAULT
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  wire logic [hrlp_pkg::TDATA_IN_W-1:0]  s_axis_tdata,  // data_byte
  output logic                                  m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  // status, line_length, method_length, uri_offset, uri_length, version_minor
  output logic [hrlp_pkg::TDATA_OUT_W-1:0]      m_axis_tdata,
  input  wire logic                             cfg_wr_en,
  input  wire logic [hrlp_pkg::LEN_W-1:0]       cfg_wr_data
);
  import hrlp_pkg::*;

  logic               in_valid;
  logic [BYTE_W-1:0]  in_byte;
  logic               fire;
  logic               s_accept;
  logic [LEN_W-1:0]   max_uri_length;
  result_t            result;
  logic               line_start;

  assign fire          = in_valid && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !in_valid || fire;
  assign s_accept      = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_uri_length <= MAX_URI_RESET;
    end else if (cfg_wr_en) begin
      max_uri_length <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_accept) begin
      in_valid <= 1'b1;
    end else if (fire) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_accept) begin
      in_byte <= s_axis_tdata[BYTE_W-1:0];
    end
  end

  hrlp_parse #(
    .COUNT_BITS(COUNT_BITS)
  ) u_parse (
    .clk            (clk),
    .rst            (rst),
    .fire           (fire),
    .data_byte      (in_byte),
    .max_uri_length (max_uri_length),
    .result         (result),
    .line_start     (line_start)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (fire) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      m_axis_tdata <= {4'b0000, result.version_minor, result.uri_length,
                       result.uri_offset, result.method_length,
                       result.line_length, result.status};
    end
  end

  // a final status always leaves the parser back at line start
  a_rearm: assert property (@(posedge clk) disable iff (rst)
    (fire && (result.status != ST_BUSY)) |=> line_start)
    else $error("parser not re-armed after final status");

  // fields other than status are zero unless the line is done
  a_fields_zero: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && (m_axis_tdata[STATUS_W-1:0] != ST_DONE)) |->
    (m_axis_tdata[TDATA_OUT_W-1:STATUS_W] == '0))
    else $error("result fields set on a status other than done");

  // a full input register behind a stalled result register takes nothing more
  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    (in_valid && m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready)
    else $error("byte taken while the pipeline is stalled");

  // status codes stay within the defined set
  a_status_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[STATUS_W-1:0] <= ST_URI_LONG))
    else $error("undefined status code");

endmodule

`default_nettype wire

>>> test/http_request_line_parser_tb.sv
// http_request_line_parser_tb: self-checking bench for the request line parser
// feeds request lines byte by byte over s_axis, predicts each result with its fields and checks m_axis
// depends on hrlp_pkg and http_request_line_parser
`default_nettype none

module http_request_line_parser_tb;
  import hrlp_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;

  typedef logic [BYTE_W-1:0] octet_t;

  logic                   clk;
  logic                   rst;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [TDATA_IN_W-1:0]  s_axis_tdata;   // data_byte
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  // status, line_length, method_length, uri_offset, uri_length, version_minor
  logic [TDATA_OUT_W-1:0] m_axis_tdata;
  logic                   cfg_wr_en;
  logic [LEN_W-1:0]       cfg_wr_data;

  http_request_line_parser DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data)
  );

  // parser state as the bench sees it
  phase_t           parser_phase;
  logic [LEN_W-1:0] stream_pos;
  logic [LEN_W-1:0] method_run;
  logic [LEN_W-1:0] uri_first;
  logic [LEN_W-1:0] uri_run;
  logic [VER_W-1:0] major_num;
  logic [VER_W-1:0] minor_num;
  logic [LEN_W-1:0] uri_limit;

  result_t expected_verdicts[$];
  octet_t  line_q[$];
  int      mismatches;
  int      cycle_count;
  int      send_idle_pct;
  int      stall_pct;
  int      hold_request;
  int      hold_left;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  function automatic logic [LEN_W-1:0] bump(input logic [LEN_W-1:0] v);
    return (v == OUT_MAX) ? v : v + 1'b1;
  endfunction

  function automatic logic dchar(input octet_t b);
    return b >= "0" && b <= "9";
  endfunction

  function automatic logic tchar(input octet_t b);
    return (b >= "A" && b <= "Z") || (b >= "a" && b <= "z") || dchar(b) ||
           b == "_" || b == "-";
  endfunction

  function automatic logic uchar(input octet_t b);
    return b >= CH_SP && b != CH_DEL;
  endfunction

  // version is judged before the uri length
  function automatic logic [STATUS_W-1:0] line_verdict();
    if (!(major_num == 1 && minor_num <= 1)) return ST_VERSION;
    if (uri_run > uri_limit) return ST_URI_LONG;
    return ST_DONE;
  endfunction

  task automatic clear_parser();
    parser_phase = PH_START;
    stream_pos   = '0;
    method_run   = '0;
    uri_first    = '0;
    uri_run      = '0;
    major_num    = '0;
    minor_num    = '0;
  endtask

  task automatic parse_request_byte(input octet_t b, output result_t res);
    logic [LEN_W-1:0]    pos;
    logic [STATUS_W-1:0] verdict;
    pos        = stream_pos;
    verdict    = ST_BUSY;
    stream_pos = bump(stream_pos);
    case (parser_phase)
      PH_START: if (b != CH_CR && b != CH_LF) begin
        if (tchar(b)) begin
          method_run   = LEN_W'(1);
          parser_phase = PH_METHOD;
        end else verdict = ST_BAD;
      end
      PH_METHOD: begin
        if (b == CH_SP) parser_phase = PH_SP_URI;
        else if (tchar(b)) method_run = bump(method_run);
        else verdict = ST_BAD;
      end
      PH_SP_URI: if (b != CH_SP) begin
        if (uchar(b)) begin
          uri_first    = pos;
          uri_run      = LEN_W'(1);
          parser_phase = PH_URI;
        end else verdict = ST_BAD;
      end
      PH_URI: begin
        if (b == CH_SP) parser_phase = PH_AFTER_URI;
        else if (uchar(b)) uri_run = bump(uri_run);
        else verdict = ST_BAD;
      end
      PH_AFTER_URI: if (b != CH_SP) begin
        if (b == CH_H) parser_phase = PH_H;
        else verdict = ST_BAD;
      end
      PH_H: if (b == CH_T) parser_phase = PH_HT; else verdict = ST_BAD;
      PH_HT: if (b == CH_T) parser_phase = PH_HTT; else verdict = ST_BAD;
      PH_HTT: if (b == CH_P) parser_phase = PH_HTTP; else verdict = ST_BAD;
      PH_HTTP: if (b == CH_SLASH) parser_phase = PH_MAJ_FIRST; else verdict = ST_BAD;
      PH_MAJ_FIRST: begin
        if (dchar(b)) begin
          major_num    = VER_W'(b - CH_ZERO);
          parser_phase = PH_MAJ;
        end else verdict = ST_BAD;
      end
      PH_MAJ: begin
        if (b == CH_DOT) parser_phase = PH_MIN_FIRST;
        else if (dchar(b) && major_num <= 9)
          major_num = VER_W'(major_num * 10 + (b - CH_ZERO));
        else verdict = ST_BAD;
      end
      PH_MIN_FIRST: begin
        if (dchar(b)) begin
          minor_num    = VER_W'(b - CH_ZERO);
          parser_phase = PH_MIN;
        end else verdict = ST_BAD;
      end
      PH_MIN: begin
        if (dchar(b)) begin
          if (minor_num <= 9) minor_num = VER_W'(minor_num * 10 + (b - CH_ZERO));
          else verdict = ST_BAD;
        end else if (b == CH_CR) parser_phase = PH_CR_SEEN;
        else if (b == CH_LF) verdict = line_verdict();
        else if (b == CH_SP) parser_phase = PH_SP_END;
        else verdict = ST_BAD;
      end
      PH_SP_END: if (b != CH_SP) begin
        if (b == CH_CR) parser_phase = PH_CR_SEEN;
        else if (b == CH_LF) verdict = line_verdict();
        else verdict = ST_BAD;
      end
      PH_CR_SEEN: if (b == CH_LF) verdict = line_verdict(); else verdict = ST_BAD;
      default: verdict = ST_BAD;
    endcase
    res        = '0;
    res.status = verdict;
    if (verdict == ST_DONE) begin
      res.line_length   = stream_pos;
      res.method_length = method_run;
      res.uri_offset    = uri_first;
      res.uri_length    = uri_run;
      res.version_minor = minor_num[0];
    end
    if (verdict != ST_BUSY) clear_parser();
  endtask

  function automatic int field_diff(input string name, input logic [LEN_W-1:0] want,
                                    input logic [LEN_W-1:0] got);
    if (want !== got) begin
      $error("%s expected %0d actual %0d", name, want, got);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk) begin : check_results
    result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_verdicts.size() == 0) begin
        $error("result transaction with nothing pending, status %0d", m_axis_tdata[2:0]);
        mismatches++;
      end else begin
        want = expected_verdicts.pop_front();
        mismatches += field_diff("status", LEN_W'(want.status), LEN_W'(m_axis_tdata[2:0]));
        mismatches += field_diff("line_length", want.line_length, m_axis_tdata[18:3]);
        mismatches += field_diff("method_length", want.method_length, m_axis_tdata[34:19]);
        mismatches += field_diff("uri_offset", want.uri_offset, m_axis_tdata[50:35]);
        mismatches += field_diff("uri_length", want.uri_length, m_axis_tdata[66:51]);
        mismatches += field_diff("version_minor", LEN_W'(want.version_minor),
                                 LEN_W'(m_axis_tdata[67]));
      end
    end
  end

  // receiver: random stalls, or a long hold-off when one is requested
  initial begin
    m_axis_tready = 1'b0;
    hold_left     = 0;
    forever begin
      @(posedge clk);
      if (hold_request != 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  task automatic send_byte(input octet_t b);
    result_t res;
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    parse_request_byte(b, res);
    expected_verdicts.push_back(res);
  endtask

  task automatic send_line();
    foreach (line_q[i]) send_byte(line_q[i]);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (expected_verdicts.size() != 0) @(posedge clk);
  endtask

  task automatic write_uri_limit(input logic [LEN_W-1:0] v);
    wait_drained();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    uri_limit    = v;
  endtask

  function automatic octet_t token_char();
    int k;
    k = $urandom_range(0, 63);
    if (k < 26) return 8'("A" + k);
    if (k < 52) return 8'("a" + (k - 26));
    if (k < 62) return 8'("0" + (k - 52));
    return (k == 62) ? "_" : "-";
  endfunction

  function automatic octet_t uri_char();
    octet_t v;
    v = 8'($urandom_range(8'h21, 8'hff));
    return (v == CH_DEL) ? "~" : v;
  endfunction

  // mostly the usual value, sometimes one to three random digits
  task automatic push_version_part(input int lo, input int hi);
    int k;
    k = $urandom_range(99);
    if (k < 80) line_q.push_back(8'(CH_ZERO + $urandom_range(lo, hi)));
    else repeat (k < 90 ? 1 : (k < 97 ? 2 : 3))
      line_q.push_back(8'(CH_ZERO + $urandom_range(9)));
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) line_q.push_back(s[i]);
  endtask

  task automatic build_request_line();
    int k;
    int n;
    line_q.delete();
    if ($urandom_range(99) < 5) begin
      repeat ($urandom_range(1, 6)) line_q.push_back(8'($urandom_range(255)));
    end else begin
      if ($urandom_range(3) == 0)
        repeat ($urandom_range(1, 2)) line_q.push_back($urandom_range(1) ? CH_CR : CH_LF);
      repeat ($urandom_range(1, 6)) line_q.push_back(token_char());
      repeat ($urandom_range(1, 2)) line_q.push_back(CH_SP);
      k = $urandom_range(99);
      n = (k < 70) ? $urandom_range(1, 12) : (k < 95) ? $urandom_range(13, 40)
                                                      : $urandom_range(41, 300);
      repeat (n) line_q.push_back(uri_char());
      repeat ($urandom_range(1, 2)) line_q.push_back(CH_SP);
      push_text("HTTP/");
      push_version_part(1, 1);
      line_q.push_back(CH_DOT);
      push_version_part(0, 1);
      if ($urandom_range(3) == 0) repeat ($urandom_range(1, 2)) line_q.push_back(CH_SP);
      if ($urandom_range(9) < 7) line_q.push_back(CH_CR);
      line_q.push_back(CH_LF);
      // broken line: one byte overwritten with anything
      if ($urandom_range(99) < 15)
        line_q[$urandom_range(0, line_q.size() - 1)] = 8'($urandom_range(255));
    end
  endtask

  task automatic run_random_lines(input int budget);
    int sent;
    sent = 0;
    while (sent < budget) begin
      build_request_line();
      send_line();
      sent += line_q.size();
    end
  endtask

  // skipped CR/LF, extreme uri byte, trailing space, then single bad bytes
  task automatic test_directed();
    send_idle_pct = 0;
    stall_pct     = 0;
    line_q.delete();
    line_q.push_back(CH_CR);
    line_q.push_back(CH_LF);
    line_q.push_back("Z");
    line_q.push_back(CH_SP);
    line_q.push_back(8'hff);
    push_text(" HTTP/1.0 \r\n");
    line_q.push_back(8'h00);
    line_q.push_back("G");
    line_q.push_back(CH_DEL);
    send_line();
    wait_drained();
  endtask

  task automatic test_idle_phase(input int idle, input int stall, input logic [LEN_W-1:0] lim,
                                 input int budget);
    write_uri_limit(lim);
    send_idle_pct = idle;
    stall_pct     = stall;
    run_random_lines(budget);
    wait_drained();
  endtask

  // receiver holds off while the sender keeps offering, so the input stalls
  task automatic test_backpressure();
    send_idle_pct = 0;
    stall_pct     = 0;
    hold_request  = 400;
    run_random_lines(80);
    wait_drained();
  endtask

  initial begin
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    cfg_wr_en     = 1'b0;
    cfg_wr_data   = '0;
    mismatches    = 0;
    cycle_count   = 0;
    hold_request  = 0;
    send_idle_pct = 0;
    stall_pct     = 0;
    uri_limit     = MAX_URI_RESET;
    clear_parser();
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    test_directed();
    test_idle_phase(0, 0, LEN_W'($urandom_range(4, 16)), 420);
    test_idle_phase(81, 0, '0, 420);
    test_idle_phase(0, 81, OUT_MAX, 420);
    test_idle_phase(33, 33, LEN_W'($urandom_range(1, 30)), 420);
    test_backpressure();

    wait_drained();
    repeat (8) @(posedge clk);
    if (expected_verdicts.size() != 0) begin
      $error("%0d expected results never arrived", expected_verdicts.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

>>> sim.f
rtl/core/hrlp_pkg.sv
rtl/core/hrlp_parse.sv
rtl/core/http_request_line_parser.sv
test/http_request_line_parser_tb.sv
